>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Clocked next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/wlda_pkg.sv
// ---------------------------------------------------------------------------
// wlda_pkg
// Types and constants for the wall line distance and angle block.
// ---------------------------------------------------------------------------
package wlda_pkg;

  localparam int CordicSteps = 16;
  localparam int AngleBits   = 16;
  localparam int PreShift    = 20;

  localparam logic [15:0] ThresholdReset = 16'd717;

  // configuration register indexes
  localparam logic REG_LASER_OFFSET = 1'b0;
  localparam logic REG_THRESHOLD    = 1'b1;

  // sector codes
  localparam logic [1:0] SEC_NONE  = 2'd0;
  localparam logic [1:0] SEC_LEFT  = 2'd1;
  localparam logic [1:0] SEC_RIGHT = 2'd2;
  localparam logic [1:0] SEC_FRONT = 2'd3;

  localparam logic signed [15:0] QuarterSec = 16'sd8192;   // 45 degrees
  localparam logic signed [15:0] ThreeQSec  = 16'sd24576;  // 135 degrees

  // arctangent table, 2^32 per turn
  function automatic logic [31:0] atan_turn(input int idx);
    logic [31:0] r;
    begin
      unique case (idx)
        0:  r = 32'h20000000;
        1:  r = 32'h12E4051E;
        2:  r = 32'h09FB385B;
        3:  r = 32'h051111D4;
        4:  r = 32'h028B0D43;
        5:  r = 32'h0145D7E1;
        6:  r = 32'h00A2F61E;
        7:  r = 32'h00517C55;
        8:  r = 32'h0028BE53;
        9:  r = 32'h00145F2F;
        10: r = 32'h000A2F98;
        11: r = 32'h000517CC;
        12: r = 32'h00028BE6;
        13: r = 32'h000145F3;
        14: r = 32'h0000A2FA;
        15: r = 32'h0000517D;
        16: r = 32'h000028BE;
        17: r = 32'h0000145F;
        18: r = 32'h00000A30;
        19: r = 32'h00000518;
        20: r = 32'h0000028C;
        21: r = 32'h00000146;
        22: r = 32'h000000A3;
        23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

  // item state through the iteration stages
  typedef struct packed {
    logic               deg;
    logic               czero;
    logic signed [39:0] x;
    logic signed [39:0] y;
    logic [31:0]        z;
    logic [67:0]        p;     // d^2 * s
    logic [49:0]        qv;    // d * s
    logic [15:0]        d;
    logic [67:0]        n2;
    logic [33:0]        s;
    logic [15:0]        rr;
    logic [15:0]        rf;
    logic [15:0]        rl;
    logic               okr;
    logic               okf;
    logic               okl;
  } iter_t;

endpackage

>>> rtl/wall_line_distance_angle.sv
// ---------------------------------------------------------------------------
// wall_line_distance_angle
// Perpendicular distance and foot angle of a wall line, sector and confirm.
// ---------------------------------------------------------------------------
// Throughput: one item per cycle; the whole pipeline holds on output stall.
// Cost per item set by the 16 shared-shape iteration stages (root and CORDIC).
// Reset: asynchronous active low, clears valid bits, offset 0, threshold 717.
module wall_line_distance_angle (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] point_a_x_i,
  input  logic [15:0] point_a_y_i,
  input  logic [15:0] point_b_x_i,
  input  logic [15:0] point_b_y_i,
  input  logic [15:0] range_right_i,
  input  logic        range_right_ok_i,
  input  logic [15:0] range_front_i,
  input  logic        range_front_ok_i,
  input  logic [15:0] range_left_i,
  input  logic        range_left_ok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] wall_distance_o,
  output logic [15:0] wall_angle_o,
  output logic [1:0]  sector_o,
  output logic        confirmed_o,
  output logic        degenerate_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import wlda_pkg::*;

  localparam int NStg = 4 + CordicSteps + 1;

  // Stage valid bits; the pipe advances as one when the output is free.
  logic [NStg-1:0] v_q;
  logic            adv;

  assign adv         = !v_q[NStg-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  logic signed [15:0] off_q;
  logic [15:0]        thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
      thr_q <= ThresholdReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LASER_OFFSET: off_q <= cfg_data_i;
        REG_THRESHOLD:    thr_q <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NStg-2:0], in_valid_i};
    end
  end

  // Range fields ride with the item through the front stages.
  typedef struct packed {
    logic [15:0] rr;
    logic [15:0] rf;
    logic [15:0] rl;
    logic        okr;
    logic        okf;
    logic        okl;
  } rng_t;

  rng_t rng1_q, rng2_q, rng3_q, rng_in;
  assign rng_in = '{rr: range_right_i, rf: range_front_i, rl: range_left_i,
                    okr: range_right_ok_i, okf: range_front_ok_i,
                    okl: range_left_ok_i};

  // Stage 1: line coefficients and coordinate products.
  logic signed [16:0] a1_q, b1_q;
  logic signed [31:0] p1_q, p2_q, o1_q, o2_q;
  logic               deg1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1_q   <= 17'($signed(point_a_y_i)) - 17'($signed(point_b_y_i));
      b1_q   <= 17'($signed(point_b_x_i)) - 17'($signed(point_a_x_i));
      p1_q   <= $signed(point_b_x_i) * $signed(point_a_y_i);
      p2_q   <= $signed(point_a_x_i) * $signed(point_b_y_i);
      o1_q   <= $signed(point_b_x_i) * off_q;
      o2_q   <= $signed(point_a_x_i) * off_q;
      deg1_q <= (point_a_x_i == point_b_x_i) && (point_a_y_i == point_b_y_i);
      rng1_q <= rng_in;
    end
  end

  // Stage 2: c, numerator magnitude, squares of a and b.
  logic signed [32:0] c2;
  logic signed [33:0] n2s;
  logic signed [16:0] a2_q, b2_q;
  logic [32:0]        na2_q, aa2_q, bb2_q;
  logic               cneg2_q, czero2_q, deg2_q;
  logic signed [33:0] aa_full, bb_full;

  assign c2      = 33'(p1_q) - 33'(p2_q);
  assign n2s     = 34'(o1_q) - 34'(o2_q) + 34'(c2);
  assign aa_full = a1_q * a1_q;
  assign bb_full = b1_q * b1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      na2_q    <= n2s[33] ? 33'(-n2s) : n2s[32:0];
      aa2_q    <= aa_full[32:0];
      bb2_q    <= bb_full[32:0];
      a2_q     <= a1_q;
      b2_q     <= b1_q;
      cneg2_q  <= c2[32];
      czero2_q <= (c2 == '0);
      deg2_q   <= deg1_q;
      rng2_q   <= rng1_q;
    end
  end

  // Stage 3: a^2+b^2 and partial products of the numerator square.
  logic [33:0]        s3_q;
  logic [33:0]        hh3_q;
  logic [32:0]        hl3_q;
  logic [31:0]        ll3_q;
  logic signed [16:0] a3_q, b3_q;
  logic               cneg3_q, czero3_q, deg3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q     <= 34'(aa2_q) + 34'(bb2_q);
      hh3_q    <= 34'(na2_q[32:16]) * 34'(na2_q[32:16]);
      hl3_q    <= 33'(na2_q[32:16]) * 33'(na2_q[15:0]);
      ll3_q    <= 32'(na2_q[15:0]) * 32'(na2_q[15:0]);
      a3_q     <= a2_q;
      b3_q     <= b2_q;
      cneg3_q  <= cneg2_q;
      czero3_q <= czero2_q;
      deg3_q   <= deg2_q;
      rng3_q   <= rng2_q;
    end
  end

  // Stage 4: numerator square and CORDIC start vector (toward the foot).
  iter_t              it_q [0:CordicSteps];
  iter_t              it0_d;
  logic signed [17:0] ea, eb;

  always_comb begin
    ea = cneg3_q ? -18'(a3_q) : 18'(a3_q);
    eb = cneg3_q ? -18'(b3_q) : 18'(b3_q);
    it0_d       = '0;
    it0_d.deg   = deg3_q;
    it0_d.czero = czero3_q;
    it0_d.n2    = 68'({hh3_q, 32'b0}) + 68'({hl3_q, 17'b0}) + 68'(ll3_q);
    it0_d.s     = s3_q;
    if (ea[17]) begin
      // left half plane: rotate by a half turn first
      it0_d.x = 40'(-ea) <<< PreShift;
      it0_d.y = 40'(-eb) <<< PreShift;
      it0_d.z = 32'h80000000;
    end else begin
      it0_d.x = 40'(ea) <<< PreShift;
      it0_d.y = 40'(eb) <<< PreShift;
      it0_d.z = 32'h0;
    end
    it0_d.rr  = rng3_q.rr;
    it0_d.rf  = rng3_q.rf;
    it0_d.rl  = rng3_q.rl;
    it0_d.okr = rng3_q.okr;
    it0_d.okf = rng3_q.okf;
    it0_d.okl = rng3_q.okl;
  end

  always_ff @(posedge clk_i) begin
    if (adv) it_q[0] <= it0_d;
  end

  // Iteration stages: one CORDIC rotation and one quotient bit each.
  for (genvar k = 0; k < CordicSteps; k++) begin : g_iter
    localparam int Bp = 15 - k;
    iter_t              nx;
    logic signed [39:0] xc, yc, xs, ys;
    logic [67:0]        cand;

    always_comb begin
      nx   = it_q[k];
      xc   = it_q[k].x;
      yc   = it_q[k].y;
      xs   = xc >>> k;
      ys   = yc >>> k;
      if (yc > 40'sd0) begin
        nx.x = xc + ys;
        nx.y = yc - xs;
        nx.z = it_q[k].z + atan_turn(k);
      end else begin
        nx.x = xc - ys;
        nx.y = yc + xs;
        nx.z = it_q[k].z - atan_turn(k);
      end
      // (d + 2^bp)^2 s = d^2 s + 2^(bp+1) d s + 2^(2bp) s
      cand = it_q[k].p + (68'(it_q[k].qv) << (Bp + 1))
           + (68'(it_q[k].s) << (2 * Bp));
      if (cand <= it_q[k].n2) begin
        nx.p  = cand;
        nx.qv = it_q[k].qv + (50'(it_q[k].s) << Bp);
        nx.d  = it_q[k].d | (16'd1 << Bp);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) it_q[k+1] <= nx;
    end
  end

  // Output stage: quarter-turn offset, rounding, sector and confirm.
  iter_t              fin;
  logic [31:0]        zf, zr;
  logic signed [15:0] ang;
  logic [1:0]         sec;
  logic               conf;

  assign fin = it_q[CordicSteps];

  always_comb begin
    zf  = (fin.czero ? 32'h0 : fin.z) - 32'h40000000;
    zr  = zf + (32'd1 << (31 - AngleBits));
    ang = zr[31:32-AngleBits];
    priority if (ang > QuarterSec && ang < ThreeQSec) begin
      sec = SEC_LEFT;
    end else if (ang > -ThreeQSec && ang < -QuarterSec) begin
      sec = SEC_RIGHT;
    end else if (ang < QuarterSec && ang > -QuarterSec) begin
      sec = SEC_FRONT;
    end else begin
      sec = SEC_NONE;
    end
    unique case (sec)
      SEC_LEFT:  conf = fin.okl && (fin.rl < thr_q);
      SEC_RIGHT: conf = fin.okr && (fin.rr < thr_q);
      SEC_FRONT: conf = fin.okf && (fin.rf < thr_q);
      default:   conf = 1'b0;
    endcase
  end

  logic [15:0] dist_q, ang_q;
  logic [1:0]  sec_q;
  logic        conf_q, deg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q <= fin.deg ? 16'd0 : fin.d;
      ang_q  <= fin.deg ? 16'd0 : ang;
      sec_q  <= fin.deg ? SEC_NONE : sec;
      conf_q <= !fin.deg && conf;
      deg_q  <= fin.deg;
    end
  end

  assign out_valid_o     = v_q[NStg-1];
  assign wall_distance_o = dist_q;
  assign wall_angle_o    = ang_q;
  assign sector_o        = sec_q;
  assign confirmed_o     = conf_q;
  assign degenerate_o    = deg_q;

endmodule

>>> rtl/wlda_checker.sv
// ---------------------------------------------------------------------------
// wlda_checker
// Port-level assertions for the wall line distance and angle block.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wlda_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] wall_distance_o,
  input logic [15:0] wall_angle_o,
  input logic [1:0]  sector_o,
  input logic        confirmed_o,
  input logic        degenerate_o
);
  import wlda_pkg::*;

  // valid holds while stalled
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  // a degenerate item carries zero fields
  `ASSERT_CLK(a_deg_zero, clk_i, rst_ni, out_valid_o && degenerate_o |->
    wall_distance_o == 16'd0 && wall_angle_o == 16'd0 && sector_o == SEC_NONE && !confirmed_o)
  // confirm needs a sector
  `ASSERT_CLK(a_conf_sec, clk_i, rst_ni, out_valid_o && confirmed_o |-> sector_o != SEC_NONE)
  // the pipe takes an item whenever the output can move
  `ASSERT_CLK(a_ready, clk_i, rst_ni, in_ready_o == (!out_valid_o || out_ready_i))

endmodule

bind wall_line_distance_angle wlda_checker u_wlda_checker (.*);
